// ----- sv/rbch_pkg.sv -----
// Shared types, constants and helper functions of the byte cipher with hex transport.
package rbch_pkg;

   // Width of the arithmetic word; products wrap to this many bits.
   localparam int ValueBits = 32;
   localparam int RedCntBits = $clog2(ValueBits);
   localparam int HexChars = 8;
   localparam int OutCntBits = $clog2(HexChars + 1);

   localparam logic [7:0] CharZero = 8'h30;
   localparam logic [7:0] CharNine = 8'h39;
   localparam logic [7:0] CharLowA = 8'h61;
   localparam logic [7:0] CharLowF = 8'h66;
   localparam logic [7:0] CharUpA  = 8'h41;
   localparam logic [7:0] CharUpF  = 8'h46;
   localparam logic [7:0] DigitTen = 8'd10;

   localparam logic [7:0] RegDirection  = 8'd0;
   localparam logic [7:0] RegModulus    = 8'd1;
   localparam logic [7:0] RegPublicExp  = 8'd2;
   localparam logic [7:0] RegPrivateExp = 8'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_RED,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic mul;
      logic red_step;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_compute;
      logic exp_le1;
      logic mod_zero;
      logic red_done;
      logic out_free;
   } dp_status_type;

   // Returns {bad, nibble}; a character that is not hex counts as zero.
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= CharZero && c <= CharNine) begin
         d = c - CharZero;
         return {1'b0, d[3:0]};
      end
      if (c >= CharLowA && c <= CharLowF) begin
         d = c - CharLowA + DigitTen;
         return {1'b0, d[3:0]};
      end
      if (c >= CharUpA && c <= CharUpF) begin
         d = c - CharUpA + DigitTen;
         return {1'b0, d[3:0]};
      end
      return 5'b10000;
   endfunction

   // Lowercase ASCII digit for one nibble.
   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return CharZero + {4'd0, nib};
      end
      return CharLowA + {4'd0, nib} - DigitTen;
   endfunction

endpackage

// ----- sv/rbch_ctrl.sv -----
// Controller state machine sequencing accept, multiply, reduction and result hand-over.
module rbch_ctrl
   import rbch_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.need_compute) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = status.exp_le1 ? ST_EMIT : ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_RED;
         end
         ST_RED: begin
            if (status.mod_zero || status.red_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.accept = req_valid;
         end
         ST_MUL:  cmd.mul = 1'b1;
         ST_RED:  cmd.red_step = 1'b1;
         ST_EMIT: cmd.emit = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

// ----- sv/rbch_dp.sv -----
// Datapath: registers, hex gathering, multiplier, bit-serial remainder and result shifter.
module rbch_dp
   import rbch_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  logic          csr_write,
   input  logic [7:0]    csr_index,
   input  logic [15:0]   csr_data,
   input  logic [7:0]    in_byte,
   input  logic          in_end,
   output logic          out_valid,
   input  logic          out_take,
   output logic [7:0]    out_byte,
   output logic          out_last,
   output logic          out_bad
);

   logic                  direction_ff;
   logic [15:0]           modulus_ff, pub_exp_ff, priv_exp_ff;
   logic [2:0]            hex_count_ff, hex_count_in;
   logic [31:0]           group_ff, group_in;
   logic                  group_bad_ff, group_bad_in;
   logic [ValueBits-1:0]  y_ff, m_ff, p_ff;
   logic [15:0]           cnt_ff, rem_ff;
   logic [RedCntBits-1:0] rcnt_ff;
   logic                  res_bad_ff, res_hex_ff;
   logic [31:0]           out_word_ff;
   logic [OutCntBits-1:0] out_left_ff;
   logic                  out_hex_ff, out_bad_ff;

   logic [4:0]            nib_info;
   logic [31:0]           new_group;
   logic                  new_bad, complete;
   logic [ValueBits-1:0]  base, product;
   logic [16:0]           trial;
   logic [15:0]           rem_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         modulus_ff   <= 16'd1;
         pub_exp_ff   <= 16'd0;
         priv_exp_ff  <= 16'd0;
      end else if (csr_write) begin
         case (csr_index)
            RegDirection:  direction_ff <= csr_data[0];
            RegModulus:    modulus_ff   <= csr_data;
            RegPublicExp:  pub_exp_ff   <= csr_data;
            RegPrivateExp: priv_exp_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign nib_info  = hex_nibble(in_byte);
   assign new_group = {group_ff[27:0], nib_info[3:0]};
   assign new_bad   = group_bad_ff | nib_info[4];
   assign complete  = (hex_count_ff == 3'(HexChars - 1));
   assign base      = direction_ff ? ValueBits'(new_group) : ValueBits'(in_byte);

   always_comb begin
      hex_count_in = hex_count_ff;
      group_in     = group_ff;
      group_bad_in = group_bad_ff;
      if (cmd.accept) begin
         if (in_end || (direction_ff && complete)) begin
            hex_count_in = 3'd0;
            group_in     = 32'd0;
            group_bad_in = 1'b0;
         end else if (direction_ff) begin
            hex_count_in = hex_count_ff + 3'd1;
            group_in     = new_group;
            group_bad_in = new_bad;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hex_count_ff <= 3'd0;
         group_ff     <= 32'd0;
         group_bad_ff <= 1'b0;
      end else begin
         hex_count_ff <= hex_count_in;
         group_ff     <= group_in;
         group_bad_ff <= group_bad_in;
      end
   end

   assign product  = y_ff * m_ff;
   assign trial    = {rem_ff, p_ff[ValueBits-1]};
   assign rem_next = (trial >= {1'b0, modulus_ff}) ? 16'(trial - {1'b0, modulus_ff})
                                                   : trial[15:0];

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         y_ff       <= base;
         m_ff       <= base;
         cnt_ff     <= direction_ff ? priv_exp_ff : pub_exp_ff;
         res_bad_ff <= direction_ff & new_bad;
         res_hex_ff <= ~direction_ff;
      end
      if (cmd.mul) begin
         p_ff    <= product;
         rem_ff  <= 16'd0;
         rcnt_ff <= '0;
      end
      if (cmd.red_step) begin
         if (modulus_ff == 16'd0) begin
            y_ff   <= p_ff;
            cnt_ff <= cnt_ff - 16'd1;
         end else begin
            p_ff    <= p_ff << 1;
            rem_ff  <= rem_next;
            rcnt_ff <= rcnt_ff + RedCntBits'(1);
            if (status.red_done) begin
               y_ff   <= ValueBits'(rem_next);
               cnt_ff <= cnt_ff - 16'd1;
            end
         end
      end
   end

   // Result shifter: eight hex beats or a single byte beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_left_ff <= '0;
      end else if (cmd.emit) begin
         out_left_ff <= res_hex_ff ? OutCntBits'(HexChars) : OutCntBits'(1);
      end else if (out_take) begin
         out_left_ff <= out_left_ff - OutCntBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_word_ff <= 32'(y_ff);
         out_hex_ff  <= res_hex_ff;
         out_bad_ff  <= res_bad_ff;
      end else if (out_take) begin
         out_word_ff <= out_word_ff << 4;
      end
   end

   assign out_valid = (out_left_ff != '0);
   assign out_byte  = out_hex_ff ? hex_digit(out_word_ff[31:28]) : out_word_ff[7:0];
   assign out_last  = (out_left_ff == OutCntBits'(1));
   assign out_bad   = out_bad_ff;

   assign status.need_compute = ~direction_ff | complete;
   assign status.exp_le1      = (cnt_ff <= 16'd1);
   assign status.mod_zero     = (modulus_ff == 16'd0);
   assign status.red_done     = (rcnt_ff == RedCntBits'(ValueBits - 1));
   assign status.out_free     = ~out_valid;

endmodule

// ----- sv/rsa_byte_cipher_hex.sv -----
// Top level of the byte-wise RSA cipher with hexadecimal transport.
// An item that needs work is checked; then, while the exponent in use (taken as 1 when it
// is zero) has powers left, it gets one multiply, a bit-serial remainder and a new check.
// With modulus zero the product only wraps. An item only filling a hex group leaves it idle.
// One item is worked on at a time; encrypt gives 8 beats, a completed hex group gives 1.
// Reset is synchronous, active high: registers return to direction 0, modulus 1, exponents 0.
module rsa_byte_cipher_hex
   import rbch_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // message_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // run_last
   output logic        rsp_tuser,   // [0] bad_char
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Configuration writes are always taken; the user must send them only while idle, unchecked here.
   assign csr_ready = 1'b1;

   // The controller steps the exponent loop; the datapath holds every data and configuration register.
   rbch_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // The result shifter sits apart from the loop, so a new beat may be accepted while
   // earlier results are still being delivered.
   rbch_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .in_byte   (req_tdata),
      .in_end    (req_tlast),
      .out_valid (rsp_tvalid),
      .out_take  (rsp_tvalid & rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast),
      .out_bad   (rsp_tuser)
   );

   // A flagged group is a single decrypt beat, so it is always the last one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("bad_char set on a beat that is not last");

   // The shifter is only reloaded once it has drained.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !rsp_tvalid)
      else $error("result loaded while beats still pending");

   // An item that only fills the hex group leaves the block ready for the next one.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !status.need_compute |=> req_tready)
      else $error("block stalled after an item without result");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the byte-wise RSA cipher with hexadecimal transport.
module testbench
   import rbch_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // One beat on the result stream as we expect to see it.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       bad_char;
   } cipher_beat_type;

   // One beat waiting to be offered on the request stream.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       message_end;
   } request_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] data_byte
   logic        req_tlast = 1'b0;   // message_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // [7:0] out_byte
   logic        rsp_tlast;          // run_last
   logic        rsp_tuser;          // [0] bad_char
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = 8'd0;
   logic [15:0] csr_data = 16'd0;

   rsa_byte_cipher_hex dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // The clock runs with a 12 ns period.
   always #6 clock = ~clock;

   // Our own copy of the register file, updated whenever a write is accepted.
   logic        dir_decrypt = 1'b0;
   logic [15:0] mod_n = 16'd1;
   logic [15:0] exp_pub = 16'd0;
   logic [15:0] exp_priv = 16'd0;

   // Our own copy of the hex gathering state.
   int          nibbles_held = 0;
   logic [31:0] gathered_word = 32'd0;
   logic        gathered_bad = 1'b0;

   request_beat_type pending_bytes[$];
   cipher_beat_type  expected_beats[$];

   int  mismatches = 0;
   int  bytes_accepted = 0;
   int  beats_checked = 0;
   int  phases_run = 0;
   int  burst_left = 0;
   int  gap_left = 0;
   bit  beat_taken = 1'b0;
   int  hold_left = 0;
   int  rx_mode = 0;
   int  rx_tick = 0;

   // Raises base to the given count (a count of zero acting as one) by repeated multiplication, wrapping every
   // product to 32 bits and reducing by the modulus unless the modulus is zero.
   function automatic logic [31:0] wrapped_power(input logic [31:0] base,
                                                 input int unsigned count);
      logic [63:0] prod;
      logic [31:0] y;
      y = base;
      for (int unsigned k = 1; k < count; k++) begin
         prod = y * base;
         y = prod[31:0];
         if (mod_n != 16'd0) begin
            y = y % {16'd0, mod_n};
         end
      end
      return y;
   endfunction

   // Lowercase ASCII character for one nibble.
   function automatic logic [7:0] nibble_char(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return CharZero + 8'(nib);
      end
      return CharLowA + 8'(nib) - 8'd10;
   endfunction

   // Works out the beats that one accepted request beat gives, and advances
   // the gathering state in the same way the block should.
   task automatic predict_cipher(input logic [7:0] data, input logic last);
      logic [31:0] c;
      logic [3:0]  nib;
      logic        bad;
      cipher_beat_type b;
      if (!dir_decrypt) begin
         c = wrapped_power({24'd0, data}, 32'(exp_pub));
         for (int k = 0; k < HexChars; k++) begin
            b.out_byte = nibble_char(c[31 - 4 * k -: 4]);
            b.run_last = (k == HexChars - 1);
            b.bad_char = 1'b0;
            expected_beats.push_back(b);
         end
         if (last) begin
            nibbles_held = 0;
            gathered_word = 32'd0;
            gathered_bad = 1'b0;
         end
      end else begin
         bad = 1'b0;
         if (data >= CharZero && data <= CharNine) begin
            nib = 4'(data - CharZero);
         end else if (data >= CharLowA && data <= CharLowF) begin
            nib = 4'(data - CharLowA + 8'd10);
         end else if (data >= CharUpA && data <= CharUpF) begin
            nib = 4'(data - CharUpA + 8'd10);
         end else begin
            nib = 4'd0;
            bad = 1'b1;
         end
         gathered_word = {gathered_word[27:0], nib};
         gathered_bad = gathered_bad | bad;
         nibbles_held++;
         if (nibbles_held == HexChars) begin
            c = wrapped_power(gathered_word, 32'(exp_priv));
            b.out_byte = c[7:0];
            b.run_last = 1'b1;
            b.bad_char = gathered_bad;
            expected_beats.push_back(b);
            nibbles_held = 0;
            gathered_word = 32'd0;
            gathered_bad = 1'b0;
         end else if (last) begin
            // A group cut short by the end of the message is dropped silently.
            nibbles_held = 0;
            gathered_word = 32'd0;
            gathered_bad = 1'b0;
         end
      end
   endtask

   // Request side: a beat is taken at the rising edge, and the prediction is
   // made there with the configuration in force at that moment.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         predict_cipher(req_tdata, req_tlast);
         bytes_accepted++;
         beat_taken = 1'b1;
      end
   end

   // Driver: works in bursts of random length separated by random gaps. A
   // beat on offer is held until it has been taken.
   always @(negedge clock) begin
      request_beat_type r;
      if (!reset && (!req_tvalid || beat_taken)) begin
         beat_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            r = pending_bytes.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= r.data_byte;
            req_tlast <= r.message_end;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 20);
               // Roughly one burst in four runs straight into the next one.
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: a long hold-off when asked for, otherwise one of three stall
   // patterns chosen per phase.
   always @(negedge clock) begin
      rx_tick++;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            0: begin
               rsp_tready <= 1'b1;
            end
            1: begin
               rsp_tready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_tready <= ((rx_tick % 7) >= 3);
            end
         endcase
      end
   end

   // Monitor: every result beat is checked against the oldest expectation.
   always @(posedge clock) begin
      cipher_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected beat out_byte=%h last=%b bad=%b", $realtime,
                     rsp_tdata, rsp_tlast, rsp_tuser);
            mismatches++;
         end else begin
            want = expected_beats.pop_front();
            beats_checked++;
            if (rsp_tdata !== want.out_byte) begin
               $display("%0t: out_byte expected %h actual %h", $realtime,
                        want.out_byte, rsp_tdata);
               mismatches++;
            end
            if (rsp_tlast !== want.run_last) begin
               $display("%0t: run_last expected %b actual %b", $realtime,
                        want.run_last, rsp_tlast);
               mismatches++;
            end
            if (rsp_tuser !== want.bad_char) begin
               $display("%0t: bad_char expected %b actual %b", $realtime,
                        want.bad_char, rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   // Writes one register through the configuration channel and mirrors it.
   task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      case (idx)
         RegDirection:  dir_decrypt = val[0];
         RegModulus:    mod_n = val;
         RegPublicExp:  exp_pub = val;
         RegPrivateExp: exp_priv = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_byte(input logic [7:0] data, input logic last);
      request_beat_type r;
      r.data_byte = data;
      r.message_end = last;
      pending_bytes.push_back(r);
   endtask

   // Queues a string of characters; the last one carries the end mark if asked.
   task automatic queue_text(input string s, input logic last);
      for (int i = 0; i < s.len(); i++) begin
         queue_byte(s[i], last && (i == s.len() - 1));
      end
   endtask

   // Waits until every beat has gone in and every expectation has been met,
   // then lets the clock run on so that a gathering-only beat has settled.
   task automatic drain;
      while (pending_bytes.size() > 0 || req_tvalid || expected_beats.size() > 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      phases_run++;
   endtask

   // A random hex character in any of the accepted spellings.
   function automatic logic [7:0] random_hex_char();
      logic [3:0] nib;
      nib = 4'($urandom_range(0, 15));
      if (nib < 4'd10) begin
         return CharZero + 8'(nib);
      end
      if ($urandom_range(0, 1) == 1) begin
         return CharUpA + 8'(nib) - 8'd10;
      end
      return CharLowA + 8'(nib) - 8'd10;
   endfunction

   initial begin
      int          want_items;
      int          queued;
      logic        last;
      logic [15:0] pick_mod;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Straight out of reset: modulus one, exponent zero, so bytes pass unchanged.
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hff, 1'b1);
      drain();

      // Encryption with a small textbook key over four sample bytes.
      write_reg(RegModulus, 16'd3233);
      write_reg(RegPublicExp, 16'd17);
      queue_byte(8'h01, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'h55, 1'b0);
      queue_byte(8'haa, 1'b1);
      drain();

      // An exponent of zero or one gives the byte itself, unreduced.
      write_reg(RegPublicExp, 16'd0);
      queue_byte(8'hc3, 1'b0);
      drain();
      write_reg(RegPublicExp, 16'd1);
      queue_byte(8'h7f, 1'b1);
      drain();

      // Modulus zero and the largest exponent: the products only wrap.
      write_reg(RegModulus, 16'd0);
      write_reg(RegPublicExp, 16'hffff);
      queue_byte(8'h03, 1'b0);
      drain();

      // Decryption; a partial group survives a change of direction.
      write_reg(RegModulus, 16'd3233);
      write_reg(RegPrivateExp, 16'd7);
      write_reg(RegDirection, 16'd1);
      queue_text("abc", 1'b0);
      drain();
      write_reg(RegDirection, 16'd0);
      write_reg(RegPublicExp, 16'd3);
      queue_byte(8'h41, 1'b0);
      drain();
      write_reg(RegDirection, 16'd1);
      queue_text("DE0f9", 1'b0);
      drain();

      // An end mark while encrypting throws away a partial group.
      queue_text("12", 1'b0);
      drain();
      write_reg(RegDirection, 16'd0);
      queue_byte(8'h10, 1'b1);
      drain();
      write_reg(RegDirection, 16'd1);

      // Characters that are not hex, a group cut short, and one closed by the end mark.
      queue_text("12g4!6", 1'b0);
      queue_byte(8'hff, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_text("123", 1'b1);
      queue_text("00000041", 1'b1);
      drain();

      // Exponents of zero, one and the largest, the widest and a zero modulus, and an index past the list.
      write_reg(RegPrivateExp, 16'd0);
      write_reg(8'd9, 16'hffff);
      queue_text("DEADBEEF", 1'b0);
      drain();
      write_reg(RegPrivateExp, 16'd1);
      write_reg(RegModulus, 16'hffff);
      queue_text("ffffffff", 1'b0);
      drain();
      write_reg(RegModulus, 16'd0);
      write_reg(RegPrivateExp, 16'hffff);
      queue_text("00000003", 1'b0);
      drain();

      // Random phases: each takes a fresh key, direction and stall pattern.
      // Exponents stay small so that the run keeps to a sensible length.
      for (int ph = 0; ph < 8; ph++) begin
         case ($urandom_range(0, 3))
            0: pick_mod = 16'd0;
            1: pick_mod = 16'd1;
            2: pick_mod = 16'hffff;
            default: pick_mod = 16'($urandom_range(2, 65535));
         endcase
         write_reg(RegModulus, pick_mod);
         write_reg(RegPublicExp, 16'($urandom_range(0, 24)));
         write_reg(RegPrivateExp, 16'($urandom_range(0, 24)));
         write_reg(RegDirection, (ph % 2 == 1) ? 16'd1 : 16'd0);
         rx_mode = (ph < 3) ? ph : $urandom_range(0, 2);
         // On the first phase, which encrypts, the receiver holds off long
         // enough for the block to fill up and push back on its input.
         if (ph == 0) begin
            hold_left = 4000;
         end
         want_items = 40;
         queued = 0;
         while (queued < want_items) begin
            if (!dir_decrypt) begin
               queue_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
               queued++;
            end else begin
               // Mostly well-formed groups of eight, now and then spoiled by
               // a stray byte or cut short by the end mark.
               for (int i = 0; i < HexChars; i++) begin
                  last = ($urandom_range(0, 15) == 0) ||
                         (i == HexChars - 1 && $urandom_range(0, 3) == 0);
                  if ($urandom_range(0, 11) == 0) begin
                     queue_byte(8'($urandom_range(0, 255)), last);
                  end else begin
                     queue_byte(random_hex_char(), last);
                  end
                  queued++;
                  if (last) begin
                     break;
                  end
               end
            end
         end
         drain();
      end

      $display("Covered %0d request beats and %0d result beats over %0d phases,",
               bytes_accepted, beats_checked, phases_run);
      $display("both directions, modulus zero to full width, exponents zero up to the largest.");
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // A run that hangs ends here; the slowest correct run is well inside this.
   initial begin
      #48_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// ----- rsa_byte_cipher_hex.f -----
sv/rbch_pkg.sv
sv/rbch_ctrl.sv
sv/rbch_dp.sv
sv/rsa_byte_cipher_hex.sv
tb/sv/testbench.sv
